### sv/ptc_pkg.sv
package ptc_pkg;

	localparam int unsigned MilliWrap  = 1000;
	localparam int unsigned SecondWrap = 60;
	localparam int unsigned MinuteWrap = 100;
	localparam logic [3:0]  LastTrackReset = 4'd10;

	typedef enum logic {
		CMD_TICK   = 1'b0,
		CMD_SAMPLE = 1'b1
	} cmd_t;

	// Key bit positions in a sample
	localparam int unsigned KeyPlay = 0;
	localparam int unsigned KeyNext = 1;
	localparam int unsigned KeyPrev = 2;
	localparam int unsigned KeyStop = 3;

	typedef struct packed {
		logic       cmd;
		logic [3:0] buttons;
	} item_t;

	typedef struct packed {
		logic [27:0] segments;
		logic        playing;
		logic [3:0]  track_number;
		logic [6:0]  minutes_out;
		logic [5:0]  seconds_out;
	} result_t;

	// Tens digit of a value below 128: multiply by reciprocal of ten
	function automatic logic [3:0] tens_of(input logic [6:0] v);
		logic [14:0] prod;
		prod = {8'd0, v} * 15'd205;
		return prod[14:11];
	endfunction

	// Seven-segment code of one decimal digit, blank otherwise
	function automatic logic [6:0] seg_of(input logic [3:0] d);
		logic [6:0] code;
		unique case (d)
			4'd0: code = 7'h3F;
			4'd1: code = 7'h06;
			4'd2: code = 7'h5B;
			4'd3: code = 7'h4F;
			4'd4: code = 7'h66;
			4'd5: code = 7'h6D;
			4'd6: code = 7'h7D;
			4'd7: code = 7'h07;
			4'd8: code = 7'h7F;
			4'd9: code = 7'h6F;
			default: code = 7'h00;
		endcase
		return code;
	endfunction

	// Two digit patterns for a value below one hundred
	function automatic logic [13:0] seg_pair(input logic [6:0] v);
		logic [3:0] tens;
		logic [6:0] ones;
		tens = tens_of(v);
		ones = v - 7'({3'd0, tens} * 7'd10);
		return {seg_of(tens), seg_of(ones[3:0])};
	endfunction

endpackage

### sv/player_timer_and_track_control.sv
// Player timer and track control. Each item is a 1 ms tick (cmd 0) or a sample of four
// active-low keys (cmd 1): play/pause, next, previous, stop, acted on as falling edges in
// that order. Every item gives one result with the MM:SS seven-segment pattern, the play
// flag, the track and the elapsed time after the item. An item is held in an input register
// and applied to the timer and track state as it moves into the result register, so the
// block takes one item per cycle while the result side does not stall. A result is held in
// the result register until taken; a stalled result holds the input register, which keeps
// one item waiting. last_track is written through the cfg channel, which is always ready.
module player_timer_and_track_control
	import ptc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_ready,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result,
	input  logic    cfg_valid,
	output logic    cfg_ready,
	input  logic [3:0] cfg_data
);

	logic       valid_s1;
	item_t      item_s1;
	logic       valid_s2;
	result_t    result_s2;
	logic       advance;

	logic [3:0] last_track_q;
	logic [9:0] milli_q;
	logic [5:0] second_q;
	logic [6:0] minute_q;
	logic       run_q;
	logic [3:0] track_q;
	logic [3:0] keys_q;

	logic [9:0] milli_d;
	logic [5:0] second_d;
	logic [6:0] minute_d;
	logic       run_d;
	logic [3:0] track_d;
	logic [3:0] keys_d;

	assign advance      = valid_s1 && (!valid_s2 || result_ready);
	assign item_ready   = !valid_s1 || advance;
	assign result_valid = valid_s2;
	assign result       = result_s2;
	assign cfg_ready    = 1'b1;

	// Hold the configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_track_q <= LastTrackReset;
		end else if (cfg_valid) begin
			last_track_q <= cfg_data;
		end
	end

	// Next state for the item in the input register
	always_comb begin
		logic [3:0] pressed;
		logic [3:0] top;
		logic [4:0] inc;
		milli_d  = milli_q;
		second_d = second_q;
		minute_d = minute_q;
		run_d    = run_q;
		track_d  = track_q;
		keys_d   = keys_q;
		pressed  = 4'd0;
		top      = (last_track_q == 4'd0) ? 4'd1 : last_track_q;
		inc      = 5'd0;
		if (item_s1.cmd == CMD_TICK) begin
			// advance the clock while playing
			if (run_q) begin
				if (milli_q == 10'(MilliWrap - 1)) begin
					milli_d = 10'd0;
					if (second_q == 6'(SecondWrap - 1)) begin
						second_d = 6'd0;
						minute_d = (minute_q == 7'(MinuteWrap - 1)) ? 7'd0 : minute_q + 7'd1;
					end else begin
						second_d = second_q + 6'd1;
					end
				end else begin
					milli_d = milli_q + 10'd1;
				end
			end
		end else begin
			pressed = ~item_s1.buttons & keys_q;
			if (pressed[KeyPlay]) begin
				run_d = !run_d;
			end
			if (pressed[KeyNext]) begin
				inc = {1'b0, track_d} + 5'd1;
				track_d = (inc > {1'b0, top}) ? 4'd1 : inc[3:0];
				{milli_d, second_d, minute_d} = '0;
				run_d = 1'b1;
			end
			if (pressed[KeyPrev]) begin
				track_d = (track_d <= 4'd1) ? top : track_d - 4'd1;
				{milli_d, second_d, minute_d} = '0;
				run_d = 1'b1;
			end
			if (pressed[KeyStop]) begin
				run_d = 1'b0;
				{milli_d, second_d, minute_d} = '0;
			end
			keys_d = item_s1.buttons;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	// Apply the item to the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			milli_q  <= '0;
			second_q <= '0;
			minute_q <= '0;
			run_q    <= 1'b0;
			track_q  <= 4'd1;
			keys_q   <= '0;
		end else if (advance) begin
			milli_q  <= milli_d;
			second_q <= second_d;
			minute_q <= minute_d;
			run_q    <= run_d;
			track_q  <= track_d;
			keys_q   <= keys_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2.segments     <= {seg_pair(minute_d), seg_pair({1'b0, second_d})};
			result_s2.playing      <= run_d;
			result_s2.track_number <= track_d;
			result_s2.minutes_out  <= minute_d;
			result_s2.seconds_out  <= second_d;
		end
	end

	a_load_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready) |=> valid_s1)
		else $error("transferred item missing from input register");

	a_track_range: assert property (@(posedge clk) disable iff (!arst_n)
		track_q != 4'd0)
		else $error("track number is zero");

	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		(second_q < 6'(SecondWrap)) && (minute_q < 7'(MinuteWrap)) &&
		(milli_q < 10'(MilliWrap)))
		else $error("elapsed time out of range");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && !result_ready) |=> (valid_s1 && $stable(track_q)))
		else $error("state moved while result stalled");

endmodule

### tb/ptc_checker.sv
`timescale 1ns / 100ps

// Watch the item, result and cfg channels, predict each readout and compare it.
module ptc_checker
	import ptc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	input  logic        item_ready,
	input  item_t       item,
	input  logic        result_valid,
	input  logic        result_ready,
	input  result_t     result,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [3:0]  cfg_data,
	output int unsigned fail_count,
	output int unsigned pending_count,
	output int unsigned readouts_checked
);

	localparam int unsigned PrintLimit = 50;

	// Predicted player state
	logic [9:0] ms_count;
	logic [5:0] sec_count;
	logic [6:0] min_count;
	logic       running;
	logic [3:0] track_q;
	logic [3:0] prev_keys;
	logic [3:0] last_track_q;

	result_t pending_readouts[$];

	initial begin
		fail_count       = 0;
		pending_count    = 0;
		readouts_checked = 0;
	end

	function automatic logic [6:0] digit_segments(input int unsigned d);
		case (d)
			0: return 7'h3F;
			1: return 7'h06;
			2: return 7'h5B;
			3: return 7'h4F;
			4: return 7'h66;
			5: return 7'h6D;
			6: return 7'h7D;
			7: return 7'h07;
			8: return 7'h7F;
			9: return 7'h6F;
			default: return 7'h00;
		endcase
	endfunction

	// MM:SS pattern, minutes tens in the top digit
	function automatic logic [27:0] clock_face(input int unsigned mins, input int unsigned secs);
		return {digit_segments(mins / 10), digit_segments(mins % 10),
			digit_segments(secs / 10), digit_segments(secs % 10)};
	endfunction

	function automatic result_t current_readout();
		result_t r;
		r.segments     = clock_face(min_count, sec_count);
		r.playing      = running;
		r.track_number = track_q;
		r.minutes_out  = min_count;
		r.seconds_out  = sec_count;
		return r;
	endfunction

	task automatic clear_clock();
		ms_count  = '0;
		sec_count = '0;
		min_count = '0;
	endtask

	// Advance the stopwatch on a tick, or act on key presses in bit order on a sample
	task automatic apply_player_item(input item_t it);
		logic [3:0]  pressed;
		int unsigned top;
		int unsigned raised_track;
		top = (last_track_q == 4'd0) ? 1 : last_track_q;
		if (it.cmd == CMD_TICK) begin
			if (running) begin
				ms_count = ms_count + 10'd1;
				if (ms_count >= MilliWrap) begin
					ms_count  = '0;
					sec_count = sec_count + 6'd1;
					if (sec_count >= SecondWrap) begin
						sec_count = '0;
						min_count = min_count + 7'd1;
						if (min_count >= MinuteWrap)
							min_count = '0;
					end
				end
			end
		end else begin
			pressed = ~it.buttons & prev_keys;
			if (pressed[KeyPlay])
				running = ~running;
			if (pressed[KeyNext]) begin
				raised_track = track_q + 1;
				track_q      = (raised_track > top) ? 4'd1 : 4'(raised_track);
				clear_clock();
				running = 1'b1;
			end
			if (pressed[KeyPrev]) begin
				if (track_q <= 4'd1)
					track_q = 4'(top);
				else
					track_q = track_q - 4'd1;
				clear_clock();
				running = 1'b1;
			end
			if (pressed[KeyStop]) begin
				running = 1'b0;
				clear_clock();
			end
			prev_keys = it.buttons;
		end
	endtask

	task automatic flag_mismatch(input string what, input logic [27:0] got,
		input logic [27:0] want);
		fail_count++;
		if (fail_count <= PrintLimit)
			$display("[%0t] MISMATCH %s: got %0h, want %0h", $time, what, got, want);
	endtask

	// Compare one readout field by field against the oldest prediction
	task automatic check_readout(input result_t got);
		result_t want;
		if (pending_readouts.size() == 0) begin
			flag_mismatch("result with none predicted, segments", got.segments, '0);
		end else begin
			want = pending_readouts.pop_front();
			readouts_checked++;
			if (got.segments !== want.segments)
				flag_mismatch("segments", got.segments, want.segments);
			if (got.playing !== want.playing)
				flag_mismatch("playing", 28'(got.playing), 28'(want.playing));
			if (got.track_number !== want.track_number)
				flag_mismatch("track_number", 28'(got.track_number),
					28'(want.track_number));
			if (got.minutes_out !== want.minutes_out)
				flag_mismatch("minutes_out", 28'(got.minutes_out), 28'(want.minutes_out));
			if (got.seconds_out !== want.seconds_out)
				flag_mismatch("seconds_out", 28'(got.seconds_out), 28'(want.seconds_out));
		end
	endtask

	// Track every transfer at the rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_clock();
			running      = 1'b0;
			track_q      = 4'd1;
			prev_keys    = 4'd0;
			last_track_q = LastTrackReset;
			pending_readouts.delete();
			pending_count = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				last_track_q = cfg_data;
			if (result_valid && result_ready)
				check_readout(result);
			if (item_valid && item_ready) begin
				apply_player_item(item);
				pending_readouts.push_back(current_readout());
			end
			pending_count = pending_readouts.size();
		end
	end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top
	import ptc_pkg::*;
();

	localparam logic [3:0] AllReleased = 4'hF;
	localparam int unsigned HoldCycles = 300;
	localparam int unsigned SecondRunTicks = 1020;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       item_valid;
	logic       item_ready;
	item_t      item;
	logic       result_valid;
	logic       result_ready;
	result_t    result;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [3:0] cfg_data;

	int unsigned fail_count;
	int unsigned pending_count;
	int unsigned readouts_checked;

	int unsigned item_count   = 0;
	int unsigned tick_count   = 0;
	int unsigned sample_count = 0;
	int unsigned cfg_writes   = 0;
	bit          steady_flow  = 1'b0;
	bit          hold_request = 1'b0;

	player_timer_and_track_control u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	ptc_checker u_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.item_valid       (item_valid),
		.item_ready       (item_ready),
		.item             (item),
		.result_valid     (result_valid),
		.result_ready     (result_ready),
		.result           (result),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_data         (cfg_data),
		.fail_count       (fail_count),
		.pending_count    (pending_count),
		.readouts_checked (readouts_checked)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mostly short gaps, a few long ones
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Offer one item, hold it until transferred, then maybe idle
	task automatic send_item(input cmd_t c, input logic [3:0] keys);
		item_t       it;
		int unsigned gap;
		it.cmd     = c;
		it.buttons = keys;
		@(negedge clk);
		item       <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (!item_ready);
		item_count++;
		if (c == CMD_TICK)
			tick_count++;
		else
			sample_count++;
		gap = (!steady_flow && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
		if (gap > 0) begin
			@(negedge clk);
			item_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// Ticks carry random key levels, which the block must ignore
	task automatic send_ticks(input int unsigned n);
		repeat (n) send_item(CMD_TICK, 4'($urandom_range(0, 15)));
	endtask

	task automatic press_keys(input logic [3:0] mask);
		send_item(CMD_SAMPLE, AllReleased);
		send_item(CMD_SAMPLE, ~mask);
	endtask

	// Stop offering and wait until every predicted readout has arrived
	task automatic wait_idle();
		@(negedge clk);
		item_valid <= 1'b0;
		while (pending_count != 0) @(negedge clk);
	endtask

	task automatic write_last_track(input logic [3:0] value);
		wait_idle();
		@(negedge clk);
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		cfg_writes++;
	endtask

	// Mostly release/press pairs and short tick runs, some raw key noise
	task automatic random_mix(input int unsigned n);
		int unsigned start;
		int unsigned r;
		logic [3:0]  mask;
		logic [3:0]  release_level;
		start = item_count;
		while (item_count - start < n) begin
			r = $urandom_range(0, 99);
			if (r < 45) begin
				mask = (r < 35) ? 4'(1 << $urandom_range(0, 3)) : 4'($urandom_range(1, 15));
				release_level = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
					: AllReleased;
				send_item(CMD_SAMPLE, release_level);
				send_item(CMD_SAMPLE, ~mask);
			end else if (r < 88) begin
				send_ticks($urandom_range(1, 40));
			end else begin
				send_item(CMD_SAMPLE, 4'($urandom_range(0, 15)));
			end
		end
	endtask

	// Stall the result side at random; honor a long hold when asked
	initial begin
		int unsigned stall_left;
		stall_left   = 0;
		result_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				stall_left   = HoldCycles;
				hold_request = 1'b0;
			end
			if (stall_left > 0) begin
				result_ready <= 1'b0;
				stall_left--;
			end else begin
				result_ready <= 1'b1;
				if (!steady_flow && $urandom_range(0, 3) == 0)
					stall_left = pick_gap();
			end
		end
	end

	initial begin
		arst_n     = 1'b0;
		item_valid = 1'b0;
		item       = '0;
		cfg_valid  = 1'b0;
		cfg_data   = 4'd0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// First sample after reset sees no press even with all keys down
		send_item(CMD_SAMPLE, 4'h0);
		press_keys(4'b0001);
		send_ticks(3);
		press_keys(4'b0010);
		send_ticks(2);
		press_keys(4'b0100);
		// Previous from track one wraps to the last track
		press_keys(4'b0100);
		press_keys(4'b0001);
		send_ticks(2);
		press_keys(4'b1000);
		// All four at once, then next and previous together
		press_keys(4'b1111);
		press_keys(4'b0110);
		send_ticks(2);

		// Hold results off while the sender keeps offering
		steady_flow  = 1'b1;
		hold_request = 1'b1;
		random_mix(80);
		steady_flow = 1'b0;
		random_mix(110);

		write_last_track(4'd15);
		random_mix(90);
		// With one track, next lands on track one from anywhere
		write_last_track(4'd1);
		press_keys(4'b0010);
		random_mix(70);
		write_last_track(4'd0);
		random_mix(60);
		// Park on track 15, then shrink the track range below it
		write_last_track(4'd15);
		press_keys(4'b0100);
		write_last_track(4'd3);
		press_keys(4'b0100);
		press_keys(4'b0010);
		random_mix(90);
		repeat (3) begin
			write_last_track(4'($urandom_range(1, 15)));
			random_mix(40);
		end

		// Run past one full second without gaps
		write_last_track(LastTrackReset);
		steady_flow = 1'b1;
		press_keys(4'b1000);
		press_keys(4'b0001);
		send_ticks(SecondRunTicks);
		press_keys(4'b1000);
		steady_flow = 1'b0;

		wait_idle();
		repeat (10) @(negedge clk);
		$display("Run covered %0d items (%0d key samples, %0d ticks), %0d last_track writes,",
			item_count, sample_count, tick_count, cfg_writes);
		$display("  %0d readouts checked, a long result hold and a run past one second.",
			readouts_checked);
		if (fail_count == 0 && pending_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Give up if the run hangs
	initial begin
		#2_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

### files.f
sv/ptc_pkg.sv
sv/player_timer_and_track_control.sv
tb/ptc_checker.sv
tb/tb_top.sv
